### sv/fgspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fgspd_pkg
// Shared types and constants of the fuzzy gain steering PD controller.
// ---------------------------------------------------------------------------
package fgspd_pkg;

  // Spacing of the gain breakpoints, in pixels of error (1..64).
  localparam int BREAK_STEP = 10;

  localparam int CENTRE_REF = 93;
  localparam int DUTY_MID   = 700;
  localparam int DUTY_MAX   = 770;
  localparam int DUTY_MIN   = 630;
  localparam int DENOM      = 256 * BREAK_STEP;

  localparam int GAIN_W = 12;
  localparam int COL_W  = 8;
  localparam int DUTY_W = 10;
  localparam int NUM_REGS = 8;
  localparam int IDX_W  = 4;

  // Shared multiplier operand widths and accumulator width.
  localparam int OPA_W = 23;
  localparam int OPB_W = 16;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W = 32;
  localparam int DIVX_W = 16;

  // Reciprocal of the step, scaled by 2**RECIP_SH and rounded up. The
  // quotient it gives is exact over the whole unsaturated duty range for
  // any step up to 64.
  localparam int RECIP_SH = 20;

  localparam logic signed [ACC_W-1:0] NUM_LO   = ACC_W'(DUTY_MIN * DENOM);
  localparam logic signed [ACC_W-1:0] NUM_HI   = ACC_W'((DUTY_MAX + 1) * DENOM);
  localparam logic signed [ACC_W-1:0] BIAS     = ACC_W'(DUTY_MID * 256);
  localparam logic [DIVX_W-1:0]       DIV_BASE = DIVX_W'(DUTY_MIN * BREAK_STEP);
  localparam logic [7:0]              STEP_A   = 8'(BREAK_STEP);
  localparam logic signed [OPB_W-1:0] STEP_B   = OPB_W'(BREAK_STEP);
  localparam logic signed [OPA_W-1:0] RECIP_A  =
    OPA_W'((2 ** RECIP_SH + BREAK_STEP - 1) / BREAK_STEP);

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_POS_BIG   = 3'd0,
    REG_POS_MID   = 3'd1,
    REG_POS_SMALL = 3'd2,
    REG_ZERO      = 3'd3,
    REG_NEG_SMALL = 3'd4,
    REG_NEG_MID   = 3'd5,
    REG_NEG_BIG   = 3'd6,
    REG_DERIV     = 3'd7
  } reg_idx_t;

  typedef logic [NUM_REGS-1:0][GAIN_W-1:0] gain_bank_t;

  // Result handed from the core to the output register.
  typedef struct packed {
    logic              vld;
    logic [DUTY_W-1:0] duty;
  } res_t;

endpackage
`default_nettype wire

### sv/fgspd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fgspd_cfg_regs
// Gain register file: seven breakpoint gains and the derivative gain.
// ---------------------------------------------------------------------------
module fgspd_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [fgspd_pkg::IDX_W-1:0]  wr_idx,
  input  wire logic [fgspd_pkg::GAIN_W-1:0] wr_data,
  output fgspd_pkg::gain_bank_t           gains
);
  import fgspd_pkg::*;

  gain_bank_t gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r[REG_POS_BIG]   <= GAIN_W'(819);
      gains_r[REG_POS_MID]   <= GAIN_W'(768);
      gains_r[REG_POS_SMALL] <= GAIN_W'(742);
      gains_r[REG_ZERO]      <= GAIN_W'(691);
      gains_r[REG_NEG_SMALL] <= GAIN_W'(742);
      gains_r[REG_NEG_MID]   <= GAIN_W'(768);
      gains_r[REG_NEG_BIG]   <= GAIN_W'(819);
      gains_r[REG_DERIV]     <= GAIN_W'(1536);
    end else if (wr_en && (wr_idx < IDX_W'(NUM_REGS))) begin
      // drop writes beyond the last register
      gains_r[wr_idx[2:0]] <= wr_data;
    end
  end

  assign gains = gains_r;

endmodule
`default_nettype wire

### sv/fgspd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fgspd_mul
// Shared signed multiplier used by every product of the control law.
// ---------------------------------------------------------------------------
module fgspd_mul (
  input  wire logic signed [fgspd_pkg::OPA_W-1:0]  op_a,
  input  wire logic signed [fgspd_pkg::OPB_W-1:0]  op_b,
  output logic signed [fgspd_pkg::PROD_W-1:0]      prod
);
  import fgspd_pkg::*;

  always_comb begin
    prod = PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule
`default_nettype wire

### sv/fgspd_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fgspd_core
// Sequencer and datapath: breakpoint search, gain blend, PD sum, saturation
// and a reciprocal-multiply quotient by the breakpoint step, all on one
// multiplier.
// ---------------------------------------------------------------------------
module fgspd_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [fgspd_pkg::COL_W-1:0] column,
  input  wire fgspd_pkg::gain_bank_t       gains,
  output logic                             idle,
  output fgspd_pkg::res_t                  res,
  input  wire logic                        res_take
);
  import fgspd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_KSTEP, S_MKD, S_MSTEP, S_MG0, S_MG1, S_MERR, S_SAT, S_DIV, S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [8:0]         last_error_r, last_error_nxt;
  logic signed [8:0]         err_r, err_nxt;
  logic signed [9:0]         delta_r, delta_nxt;
  logic [7:0]                a_r, a_nxt;
  logic                      pos_r, pos_nxt;
  logic [1:0]                k_r, k_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [OPA_W-1:0]   kp_r, kp_nxt;
  logic [DIVX_W-1:0]         x_r, x_nxt;
  logic [DUTY_W-1:0]         duty_r, duty_nxt;

  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [8:0]         err_in;
  logic [1:0]                k_hi;

  fgspd_mul u_mul (
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Gain at breakpoint k on the side of the error's sign.
  function automatic logic [GAIN_W-1:0] gain_at(gain_bank_t bank, logic pos, logic [1:0] k);
    logic [2:0] idx;
    idx = pos ? (3'(REG_ZERO) - {1'b0, k}) : (3'(REG_ZERO) + {1'b0, k});
    return bank[idx];
  endfunction

  always_comb begin
    err_in  = 9'(CENTRE_REF) - $signed({1'b0, column});
    k_hi    = (k_r == 2'd3) ? k_r : (k_r + 2'd1);

    state_nxt      = state_r;
    last_error_nxt = last_error_r;
    err_nxt        = err_r;
    delta_nxt      = delta_r;
    a_nxt          = a_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    kp_nxt         = kp_r;
    x_nxt          = x_r;
    duty_nxt       = duty_r;
    op_a           = '0;
    op_b           = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          err_nxt        = err_in;
          delta_nxt      = {err_in[8], err_in} - {last_error_r[8], last_error_r};
          last_error_nxt = err_in;
          pos_nxt        = !err_in[8];
          a_nxt          = err_in[8] ? 8'(-err_in) : err_in[7:0];
          k_nxt          = '0;
          state_nxt      = S_KSTEP;
        end
      end
      // Split |error| into segment index and offset, one subtract per cycle.
      S_KSTEP: begin
        if (k_r == 2'd3) begin
          a_nxt     = '0;
          state_nxt = S_MKD;
        end else if (a_r < STEP_A) begin
          state_nxt = S_MKD;
        end else begin
          a_nxt = a_r - STEP_A;
          k_nxt = k_r + 2'd1;
        end
      end
      S_MKD: begin
        op_a      = OPA_W'(gains[REG_DERIV]);
        op_b      = OPB_W'(delta_r);
        acc_nxt   = BIAS + ACC_W'(prod);
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        op_a      = acc_r[OPA_W-1:0];
        op_b      = STEP_B;
        acc_nxt   = ACC_W'(prod);
        state_nxt = S_MG0;
      end
      S_MG0: begin
        op_a      = OPA_W'(gain_at(gains, pos_r, k_r));
        op_b      = STEP_B - $signed(OPB_W'(a_r));
        kp_nxt    = prod[OPA_W-1:0];
        state_nxt = S_MG1;
      end
      S_MG1: begin
        op_a      = OPA_W'(gain_at(gains, pos_r, k_hi));
        op_b      = $signed(OPB_W'(a_r));
        kp_nxt    = kp_r + prod[OPA_W-1:0];
        state_nxt = S_MERR;
      end
      S_MERR: begin
        op_a      = kp_r;
        op_b      = OPB_W'(err_r);
        acc_nxt   = acc_r + ACC_W'(prod);
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (acc_r < NUM_LO) begin
          duty_nxt  = DUTY_W'(DUTY_MIN);
          state_nxt = S_DONE;
        end else if (acc_r >= NUM_HI) begin
          duty_nxt  = DUTY_W'(DUTY_MAX);
          state_nxt = S_DONE;
        end else begin
          x_nxt     = acc_r[DIVX_W+7:8] - DIV_BASE;
          state_nxt = S_DIV;
        end
      end
      // Quotient by the step through the scaled reciprocal, in one product.
      S_DIV: begin
        op_a      = RECIP_A;
        op_b      = OPB_W'(x_r);
        duty_nxt  = DUTY_W'(DUTY_MIN) + DUTY_W'(prod[RECIP_SH+7:RECIP_SH]);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    err_r   <= err_nxt;
    delta_r <= delta_nxt;
    a_r     <= a_nxt;
    pos_r   <= pos_nxt;
    k_r     <= k_nxt;
    acc_r   <= acc_nxt;
    kp_r    <= kp_nxt;
    x_r     <= x_nxt;
    duty_r  <= duty_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_error_r <= '0;
    end else begin
      state_r      <= state_nxt;
      last_error_r <= last_error_nxt;
    end
  end

  assign idle     = (state_r == S_IDLE);
  assign res.vld  = (state_r == S_DONE);
  assign res.duty = duty_r;

endmodule
`default_nettype wire

### sv/fuzzy_gain_steering_pd.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: breakpoint search, then the derivative, step and gain-blend
//   products, the error product, saturation and a reciprocal-multiply
//   quotient, which is skipped when the duty saturates; one shared multiplier.
// Flow: one item in work at a time; the output register lets the next item
//   start while a result waits for out_tready.
// Reset: rst_n synchronous, active low; gains return to defaults, last error to 0.
// ---------------------------------------------------------------------------
// fuzzy_gain_steering_pd
// Fuzzy gain-scheduled PD steering controller: lane centre column in,
// saturated servo duty out.
// ---------------------------------------------------------------------------
module fuzzy_gain_steering_pd (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] centre_column
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [9:0] servo_duty, [15:10] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import fgspd_pkg::*;

  gain_bank_t        gains;
  res_t              res;
  logic              core_idle;
  logic              in_acc;
  logic              res_take;
  logic              out_valid_r;
  logic [DUTY_W-1:0] out_duty_r;

  // Register writes never stall; always take them.
  assign cfg_ready = 1'b1;

  fgspd_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .gains   (gains)
  );

  // Take a new item whenever the sequencer is idle.
  assign in_tready = core_idle;
  assign in_acc    = in_tvalid && in_tready;

  fgspd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .column   (in_tdata[COL_W-1:0]),
    .gains    (gains),
    .idle     (core_idle),
    .res      (res),
    .res_take (res_take)
  );

  // Move a finished result into the output register when it is empty or
  // being drained this cycle; otherwise hold the core in its done state.
  assign res_take = res.vld && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_duty_r <= res.duty;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_duty_r};

endmodule
`default_nettype wire

### sv/fgspd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fgspd_checker
// Port-level checks of the steering controller, bound to the top level.
// ---------------------------------------------------------------------------
module fgspd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // One item at a time: busy right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // No result can appear in the cycle right after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // Duty always inside the saturation band.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[9:0] >= 10'd630) && (out_tdata[9:0] <= 10'd770)
                   && (out_tdata[15:10] == 6'd0))
    else $error("servo duty outside 630..770");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind fuzzy_gain_steering_pd fgspd_checker u_fgspd_checker (.*);
`default_nettype wire
